@@ sv/rrt_pkg.sv @@
// Shared types and constants of the RPC retransmit table.
`default_nettype none
package rrt_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam logic [7:0]  ThresholdReset = 8'd5;

  // Input item modes (tuser on the slave side); code 3 is ignored.
  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_REPLY = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  // Result kinds (tuser on the master side)
  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_MATCHED   = 3'd2,
    KIND_UNMATCHED = 3'd3,
    KIND_RESEND    = 3'd4
  } kind_t;

  // One table entry as held in the entry memory
  typedef struct packed {
    logic [31:0] xid;
    logic [15:0] port;
    logic [7:0]  tag;
    logic        handler;
    logic [7:0]  age;
  } entry_t;

  // One result as held in the output register
  typedef struct packed {
    kind_t       kind;
    logic [31:0] xid;
    logic [15:0] port;
    logic [7:0]  tag;
    logic        handler;
    logic        last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_MISS,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_TICK_FLUSH
  } state_t;

endpackage
`default_nettype wire

@@ sv/rrt_mem.sv @@
// Entry memory: one write port, one read port with registered read data.
`default_nettype none
module rrt_mem #(
  parameter int unsigned Depth = rrt_pkg::DepthDefault,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [IdxW-1:0] wr_addr,
  input  wire rrt_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [IdxW-1:0] rd_addr,
  output rrt_pkg::entry_t      rd_data
);
  import rrt_pkg::*;

  entry_t mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ sv/rrt_ctrl.sv @@
// Sequencer: walks the entry memory one entry at a time for reply and tick; add writes a single entry.
`default_nettype none
module rrt_ctrl #(
  parameter int unsigned Depth = rrt_pkg::DepthDefault,
  localparam int unsigned IdxW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       threshold,
  // input item
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rrt_pkg::mode_t   in_mode,
  input  wire logic [31:0]      in_xid,
  input  wire logic [15:0]      in_port,
  input  wire logic [7:0]       in_tag,
  input  wire logic             in_handler,
  // result
  output logic                  res_valid,
  input  wire logic             res_ready,
  output rrt_pkg::result_t      res,
  // entry memory
  output logic                  wr_en,
  output logic [IdxW-1:0]       wr_addr,
  output rrt_pkg::entry_t       wr_data,
  output logic                  rd_en,
  output logic [IdxW-1:0]       rd_addr,
  input  wire rrt_pkg::entry_t  rd_data
);
  import rrt_pkg::*;

  localparam logic [CntW-1:0] CountFull = CntW'(Depth);
  localparam logic [CntW-1:0] CountOne  = CntW'(1);

  state_t          state, state_next;
  logic [CntW-1:0] count, count_next;
  logic [CntW-1:0] idx, idx_next;
  logic [CntW-1:0] idx_inc;
  logic [31:0]     xid;
  logic [15:0]     port;
  logic [7:0]      tag;
  logic            handler;
  logic            pend_valid, pend_valid_next;
  entry_t          pend, pend_next;
  logic            emit;
  result_t         emit_res;
  logic            out_free;
  logic            hit;
  logic            due;
  logic            at_end;
  logic            in_xfer;
  logic [7:0]      age_inc;

  assign out_free = !res_valid || res_ready;
  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign idx_inc  = idx + CountOne;
  assign at_end   = (idx_inc == count);

  // compare unit on the registered read data
  assign hit     = (rd_data.xid == xid);
  assign due     = (rd_data.age > threshold);
  assign age_inc = (rd_data.age == 8'hFF) ? 8'hFF : rd_data.age + 8'd1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_mode)
            MODE_ADD:   state_next = ST_ADD;
            MODE_REPLY: state_next = (count == '0) ? ST_MISS : ST_FIND_RD;
            MODE_TICK:  state_next = (count == '0) ? ST_IDLE : ST_TICK_RD;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD:      if (out_free) state_next = ST_IDLE;
      ST_FIND_RD:  state_next = ST_FIND_CHK;
      ST_FIND_CHK: begin
        if (hit) begin
          if (out_free) state_next = ST_SHIFT_RD;
        end else begin
          state_next = at_end ? ST_MISS : ST_FIND_RD;
        end
      end
      ST_MISS:     if (out_free) state_next = ST_IDLE;
      ST_SHIFT_RD: state_next = at_end ? ST_IDLE : ST_SHIFT_WR;
      ST_SHIFT_WR: state_next = ST_SHIFT_RD;
      ST_TICK_RD:  state_next = ST_TICK_CHK;
      ST_TICK_CHK: begin
        if (!(due && pend_valid && !out_free)) begin
          state_next = at_end ? ST_TICK_FLUSH : ST_TICK_RD;
        end
      end
      ST_TICK_FLUSH: if (!pend_valid || out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    count_next      = count;
    idx_next        = idx;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    emit            = 1'b0;
    emit_res        = '{kind: KIND_ADDED, xid: xid, port: 16'd0, tag: 8'd0,
                        handler: 1'b0, last: 1'b1};
    wr_en           = 1'b0;
    wr_addr         = idx[IdxW-1:0];
    wr_data         = rd_data;
    rd_en           = 1'b0;
    rd_addr         = idx[IdxW-1:0];
    case (state)
      ST_IDLE: begin
        idx_next = '0;
      end
      ST_ADD: begin
        if (out_free) begin
          emit = 1'b1;
          if (count == CountFull) begin
            emit_res.kind = KIND_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = count[IdxW-1:0];
            wr_data    = '{xid: xid, port: port, tag: tag, handler: handler, age: 8'd0};
            count_next = count + CountOne;
          end
        end
      end
      ST_FIND_RD: begin
        rd_en = 1'b1;
      end
      ST_FIND_CHK: begin
        if (hit) begin
          if (out_free) begin
            emit     = 1'b1;
            emit_res = '{kind: KIND_MATCHED, xid: rd_data.xid, port: rd_data.port,
                         tag: rd_data.tag, handler: rd_data.handler, last: 1'b1};
          end
        end else begin
          idx_next = idx_inc;
        end
      end
      ST_MISS: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_res.kind = KIND_UNMATCHED;
        end
      end
      ST_SHIFT_RD: begin
        if (at_end) begin
          count_next = count - CountOne;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[IdxW-1:0];
        end
      end
      ST_SHIFT_WR: begin
        // move the following entry down over the removed one
        wr_en    = 1'b1;
        idx_next = idx_inc;
      end
      ST_TICK_RD: begin
        rd_en = 1'b1;
      end
      ST_TICK_CHK: begin
        if (due) begin
          if (!pend_valid || out_free) begin
            // the held resend is not the last one: send it now
            emit            = pend_valid;
            emit_res        = '{kind: KIND_RESEND, xid: pend.xid, port: pend.port,
                                tag: pend.tag, handler: pend.handler, last: 1'b0};
            pend_valid_next = 1'b1;
            pend_next       = rd_data;
            wr_en           = 1'b1;
            wr_data.age     = 8'd0;
            idx_next        = idx_inc;
          end
        end else begin
          wr_en       = 1'b1;
          wr_data.age = age_inc;
          idx_next    = idx_inc;
        end
      end
      ST_TICK_FLUSH: begin
        if (pend_valid && out_free) begin
          emit            = 1'b1;
          emit_res        = '{kind: KIND_RESEND, xid: pend.xid, port: pend.port,
                              tag: pend.tag, handler: pend.handler, last: 1'b1};
          pend_valid_next = 1'b0;
        end
      end
      default: begin
        idx_next = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      idx        <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      idx        <= idx_next;
      pend_valid <= pend_valid_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (emit) begin
      res <= emit_res;
    end
    if (in_xfer) begin
      xid     <= in_xid;
      port    <= in_port;
      tag     <= in_tag;
      handler <= in_handler;
    end
  end

endmodule
`default_nettype wire

@@ sv/rpc_retransmit_table_unit.sv @@
// Top level of the RPC retransmit table: stream ports, threshold register, sequencer, memory.
//
//  channel | dir | handshake           | contents
//  s_*     | in  | s_tvalid / s_tready | tuser: mode; tdata: xid, dest_port, buffer_tag,
//          |     |                     |   has_handler
//  m_*     | out | m_tvalid / m_tready | tuser: kind; tdata: out_xid, out_port, out_tag,
//          |     |                     |   out_handler; tlast: last
//  cfg_*   | in  | cfg_valid/cfg_ready | cfg_data: resend_threshold
//
// One item at a time; s_tready is high only while the sequencer is idle.
// Add: writes the entry after the last stored one, or reports the table full.
// Reply: reads entries in order until one matches, then moves each later entry down by one.
// Tick: walks every stored entry; each entry costs one memory read and one write.
// Stalls on m_tready hold the sequencer only when a new result must be written out.
// Synchronous reset empties the table and sets the threshold to 5; no clearing pass.
`default_nettype none
module rpc_retransmit_table_unit #(
  parameter int unsigned TABLE_DEPTH = rrt_pkg::DepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [31:0] xid, [47:32] dest_port, [55:48] buffer_tag,
                                      // [56] has_handler, [63:57] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [31:0] out_xid, [47:32] out_port, [55:48] out_tag,
                                      // [56] out_handler, [63:57] zero
  output logic [2:0]       m_tuser,   // [2:0] kind
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);
  import rrt_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  logic [7:0]      threshold;
  result_t         res;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  entry_t          rd_data;
  logic [6:0]      unused_pad;

  // threshold register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ThresholdReset;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  assign unused_pad = s_tdata[63:57];

  rrt_ctrl #(.Depth(TABLE_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .threshold  (threshold),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_mode    (mode_t'(s_tuser)),
    .in_xid     (s_tdata[31:0]),
    .in_port    (s_tdata[47:32]),
    .in_tag     (s_tdata[55:48]),
    .in_handler (s_tdata[56]),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  rrt_mem #(.Depth(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result packing
  assign m_tdata = {7'd0, res.handler, res.tag, res.port, res.xid};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule
`default_nettype wire

@@ tb/sv/rrt_tb_pkg.sv @@
// Tracker of outstanding RPC requests that predicts the retransmit table's result stream.
`timescale 1ns / 100ps
package rrt_tb_pkg;
  import rrt_pkg::*;

  class rpc_table_tracker;
    int unsigned depth;
    logic [7:0]  threshold;
    entry_t      pending_requests[$];     // oldest first
    result_t     outstanding_results[$];  // results not yet seen on the master side
    int unsigned failures;

    function new(int unsigned table_depth);
      depth = table_depth;
      threshold = ThresholdReset;
      failures = 0;
    endfunction

    // xid of a random pending request, so that replies can hit; caller checks size
    function logic [31:0] random_pending_xid();
      return pending_requests[$urandom_range(0, pending_requests.size() - 1)].xid;
    endfunction

    // Apply one accepted input transfer and queue the results it causes
    function void accept_item(logic [1:0] mode, logic [31:0] xid, logic [15:0] port,
                              logic [7:0] tag, logic handler);
      entry_t      e;
      result_t     r;
      int          found;
      int unsigned due;
      int unsigned sent;
      r = '0;
      r.xid = xid;
      r.last = 1'b1;
      case (mode)
        MODE_ADD: begin
          if (pending_requests.size() >= depth) begin
            r.kind = KIND_FULL;
          end else begin
            e.xid = xid;
            e.port = port;
            e.tag = tag;
            e.handler = handler;
            e.age = '0;
            pending_requests.push_back(e);
            r.kind = KIND_ADDED;
          end
          outstanding_results.push_back(r);
        end
        MODE_REPLY: begin
          // oldest entry with an equal xid wins
          found = -1;
          foreach (pending_requests[i])
            if (found < 0 && pending_requests[i].xid == xid) found = i;
          if (found < 0) begin
            r.kind = KIND_UNMATCHED;
          end else begin
            e = pending_requests[found];
            r.kind = KIND_MATCHED;
            r.port = e.port;
            r.tag = e.tag;
            r.handler = e.handler;
            pending_requests.delete(found);
          end
          outstanding_results.push_back(r);
        end
        MODE_TICK: begin
          // count due entries first so the final resend can carry last
          due = 0;
          foreach (pending_requests[i])
            if (pending_requests[i].age > threshold) due++;
          sent = 0;
          foreach (pending_requests[i]) begin
            e = pending_requests[i];
            if (e.age > threshold) begin
              sent++;
              r.kind = KIND_RESEND;
              r.xid = e.xid;
              r.port = e.port;
              r.tag = e.tag;
              r.handler = e.handler;
              r.last = (sent == due);
              outstanding_results.push_back(r);
              e.age = '0;
            end else if (e.age != 8'hFF) begin
              e.age = e.age + 8'd1;
            end
            pending_requests[i] = e;
          end
        end
        default: ;  // ignored mode
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
        failures++;
      end
    endfunction

    // Check one result transfer against the oldest outstanding result
    function void check_result(logic [2:0] kind, logic [63:0] data, logic last);
      result_t want;
      if (outstanding_results.size() == 0) begin
        $display("%0t: unexpected result, kind %0d xid %h last %b",
                 $time, kind, data[31:0], last);
        failures++;
        return;
      end
      want = outstanding_results.pop_front();
      compare_field("kind", 32'(want.kind), 32'(kind));
      compare_field("xid", want.xid, data[31:0]);
      compare_field("port", 32'(want.port), 32'(data[47:32]));
      compare_field("tag", 32'(want.tag), 32'(data[55:48]));
      compare_field("handler", 32'(want.handler), 32'(data[56]));
      compare_field("pad", 32'd0, 32'(data[63:57]));
      compare_field("last", 32'(want.last), 32'(last));
    endfunction

    function void check_drained();
      if (outstanding_results.size() != 0) begin
        $display("%0t: %0d results never arrived, oldest kind %0d xid %h", $time,
                 outstanding_results.size(), outstanding_results[0].kind,
                 outstanding_results[0].xid);
        failures++;
      end
    endfunction
  endclass

endpackage

@@ tb/sv/tb.sv @@
// Top-level testbench of the RPC retransmit table: stimulus, flow control and result checks.
`timescale 1ns / 100ps
module tb;
  import rrt_pkg::*;
  import rrt_tb_pkg::*;

  localparam int unsigned PauseCycles   = 80;    // covers the longest reply or tick walk
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 24;
  localparam logic [1:0]  ModeIgnored   = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  rpc_table_tracker tracker;

  rpc_retransmit_table_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (m_tvalid && m_tready) tracker.check_result(m_tuser, m_tdata, m_tlast);
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // One input transfer; tvalid stays high afterwards unless the next call idles
  task automatic send_item(input logic [1:0] mode, input logic [31:0] xid,
                           input logic [15:0] port, input logic [7:0] tag,
                           input logic handler);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {7'd0, handler, tag, port, xid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.accept_item(mode, xid, port, tag, handler);
  endtask

  // Threshold write once the block has drained and gone idle
  task automatic write_threshold(input logic [7:0] value);
    s_tvalid <= 1'b0;
    while (tracker.outstanding_results.size() != 0) @(posedge clk);
    repeat (PauseCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.threshold = value;
    cfg_valid <= 1'b0;
  endtask

  // Small pool of xids gives duplicates and hits; full range toggles every bit
  function automatic logic [31:0] random_xid();
    if ($urandom_range(0, 1) == 0) return 32'($urandom_range(0, 7));
    return $urandom;
  endfunction

  task automatic random_item(output bit counted);
    int unsigned pick;
    logic [31:0] xid;
    pick = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 5) begin
      send_item(ModeIgnored, $urandom, 16'($urandom), 8'($urandom), 1'($urandom));
      counted = 1'b0;
    end else if (pick < 40) begin
      send_item(MODE_ADD, random_xid(), 16'($urandom), 8'($urandom), 1'($urandom));
    end else if (pick < 75) begin
      if (tracker.pending_requests.size() != 0 && $urandom_range(0, 99) < 75)
        xid = tracker.random_pending_xid();
      else
        xid = random_xid();
      send_item(MODE_REPLY, xid, 16'($urandom), 8'($urandom), 1'($urandom));
    end else begin
      send_item(MODE_TICK, $urandom, 16'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic run_phase(input logic [7:0] threshold, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    int unsigned n;
    bit counted;
    write_threshold(threshold);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    n = 0;
    while (n < PhaseItems) begin
      random_item(counted);
      if (counted) n++;
    end
  endtask

  initial begin
    tracker = new(DepthDefault);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, ignored mode, field extremes, duplicates
    send_item(MODE_TICK, 32'h0, 16'h0, 8'h0, 1'b0);
    send_item(ModeIgnored, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1);
    send_item(MODE_REPLY, 32'h0, 16'h0, 8'h0, 1'b0);
    send_item(MODE_ADD, 32'h0, 16'h0, 8'h0, 1'b0);
    send_item(MODE_ADD, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1);
    send_item(MODE_ADD, 32'hFFFF_FFFF, 16'h1234, 8'h5A, 1'b0);
    send_item(MODE_REPLY, 32'hFFFF_FFFF, 16'h0, 8'h0, 1'b0);
    // fill to depth, then one add too many
    for (int i = 0; i < 14; i++)
      send_item(MODE_ADD, 32'h1000 + i, 16'(i * 4099), 8'(i * 17), 1'(i));
    send_item(MODE_ADD, 32'hDEAD_0001, 16'h8000, 8'h80, 1'b1);
    // at the reset threshold the seventh tick resends every entry
    for (int i = 0; i < 7; i++)
      send_item(MODE_TICK, 32'h0, 16'h0, 8'h0, 1'b0);

    // Random phases with different thresholds and flow control
    run_phase(8'd0, 0, 0);
    run_phase(8'd2, 72, 0);
    run_phase(8'd255, 0, 72);
    run_phase(8'd1, 32, 32);

    s_tvalid <= 1'b0;
    while (tracker.outstanding_results.size() != 0) @(posedge clk);
    repeat (PauseCycles) @(posedge clk);
    tracker.check_drained();
    if (tracker.failures == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
